@@ rtl/pps_pkg.sv @@
package pps_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int ENTRY_W       = $clog2(MAX_PROCESSES);

    localparam int IDX_W     = 4;
    localparam int TIME_W    = 16;
    localparam int BURST_W   = 8;
    localparam int PRI_W     = 3;
    localparam int OUTCOME_W = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_LOAD = 2'd0,
        OUT_RUN  = 2'd1,
        OUT_IDLE = 2'd2
    } t_outcome;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_RUN,
        S_FIN,
        S_EMIT
    } t_state;

endpackage

@@ rtl/preemptive_priority_scheduler_unit.sv @@
// Preemptive priority scheduler over a table of 16 process entries.
// Request channel: i_in_valid / o_in_ready with i_command and the entry fields.
//   A load request writes one entry; a tick request runs the most urgent
//   eligible entry for one unit and then advances the time counter.
// Result channel: o_out_valid / i_out_ready, one result per request.
// Sequence: a load passes through S_LOAD and S_EMIT to the result register;
//   a tick scans the entries in turn in S_SCAN through a single
//   priority/arrival comparator, then retires the winner in S_RUN, does the
//   waiting-time subtract in S_FIN and moves the result out in S_EMIT.
// The block takes one request at a time; o_in_ready is high only when the
//   sequencer is idle, so the next request is not taken until the result of
//   the last one has moved to the output register.
// A finished result sits in the output register while the next request is
//   accepted and processed; if the receiver stalls, the sequencer holds the
//   new result until the output register is taken.
// Reset clears all entry valid bits, the time counter and the result valid.
module preemptive_priority_scheduler_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_command,
    input  logic [pps_pkg::IDX_W-1:0]       i_process_index,
    input  logic [pps_pkg::TIME_W-1:0]      i_arrival_time,
    input  logic [pps_pkg::BURST_W-1:0]     i_burst_time,
    input  logic [pps_pkg::PRI_W-1:0]       i_priority_level,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [pps_pkg::OUTCOME_W-1:0]   o_outcome,
    output logic [pps_pkg::IDX_W-1:0]       o_running_index,
    output logic                            o_finished,
    output logic [pps_pkg::TIME_W-1:0]      o_turnaround_time,
    output logic [pps_pkg::TIME_W-1:0]      o_waiting_time,
    output logic [pps_pkg::TIME_W-1:0]      o_tick_time
);
    import pps_pkg::*;

    t_state r_state, n_state;

    logic                 r_cmd;
    logic [IDX_W-1:0]     r_idx;
    logic [TIME_W-1:0]    r_arr_in;
    logic [BURST_W-1:0]   r_burst_in;
    logic [PRI_W-1:0]     r_pri_in;

    logic                 r_valid  [MAX_PROCESSES];
    logic [TIME_W-1:0]    r_arrival[MAX_PROCESSES];
    logic [BURST_W-1:0]   r_burst  [MAX_PROCESSES];
    logic [PRI_W-1:0]     r_prio   [MAX_PROCESSES];
    logic [BURST_W-1:0]   r_remain [MAX_PROCESSES];

    logic [TIME_W-1:0]    r_time;

    logic [ENTRY_W-1:0]   r_scan;
    logic                 r_found;
    logic [ENTRY_W-1:0]   r_best_idx;
    logic [PRI_W-1:0]     r_best_pri;
    logic [TIME_W-1:0]    r_best_arr;
    logic [BURST_W-1:0]   r_best_burst;
    logic [BURST_W-1:0]   r_best_rem;

    t_outcome             r_res_outcome;
    logic [IDX_W-1:0]     r_res_index;
    logic                 r_res_fin;
    logic [TIME_W-1:0]    r_res_ta;
    logic [TIME_W-1:0]    r_res_wt;

    logic                 r_out_valid;
    t_outcome             r_out_outcome;
    logic [IDX_W-1:0]     r_out_index;
    logic                 r_out_fin;
    logic [TIME_W-1:0]    r_out_ta;
    logic [TIME_W-1:0]    r_out_wt;
    logic [TIME_W-1:0]    r_out_tick;

    logic                 in_ready;
    logic                 in_accept;
    logic                 scan_last;
    logic                 emit_go;
    logic                 s_elig;
    logic                 s_better;
    logic                 load_hit;
    logic [BURST_W-1:0]   rem_dec;
    logic [TIME_W:0]      ta_full;
    logic [TIME_W-1:0]    ta_sat;
    logic [TIME_W-1:0]    burst_ext;

    assign s_elig    = r_valid[r_scan] && (r_remain[r_scan] != '0)
                       && (r_arrival[r_scan] <= r_time);
    assign s_better  = !r_found
                       || ({r_prio[r_scan], r_arrival[r_scan]} < {r_best_pri, r_best_arr});
    assign load_hit  = (int'(r_idx) < MAX_PROCESSES);
    assign rem_dec   = r_best_rem - BURST_W'(1);
    assign ta_full   = {1'b0, r_time} + (TIME_W+1)'(1) - {1'b0, r_best_arr};
    assign ta_sat    = ta_full[TIME_W] ? '1 : ta_full[TIME_W-1:0];
    assign burst_ext = {{(TIME_W-BURST_W){1'b0}}, r_best_burst};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_command == CMD_LOAD) ? S_LOAD : S_SCAN;
                end
            end
            S_LOAD: n_state = S_EMIT;
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_RUN;
                end
            end
            S_RUN:  n_state = S_FIN;
            S_FIN:  n_state = S_EMIT;
            S_EMIT: begin
                if (emit_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = (r_state == S_IDLE);
        in_accept = in_ready && i_in_valid;
        scan_last = (r_state == S_SCAN) && (r_scan == ENTRY_W'(MAX_PROCESSES - 1));
        emit_go   = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_time      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_PROCESSES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if ((r_state == S_LOAD) && load_hit) begin
                r_valid[r_idx[ENTRY_W-1:0]] <= 1'b1;
            end
            if (emit_go && (r_cmd == CMD_TICK) && (r_time != '1)) begin
                r_time <= r_time + TIME_W'(1);
            end
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd      <= i_command;
            r_idx      <= i_process_index;
            r_arr_in   <= i_arrival_time;
            r_burst_in <= i_burst_time;
            r_pri_in   <= i_priority_level;
            r_scan     <= '0;
            r_found    <= 1'b0;
        end

        if (r_state == S_SCAN) begin
            r_scan <= r_scan + ENTRY_W'(1);
            if (s_elig && s_better) begin
                r_found      <= 1'b1;
                r_best_idx   <= r_scan;
                r_best_pri   <= r_prio[r_scan];
                r_best_arr   <= r_arrival[r_scan];
                r_best_burst <= r_burst[r_scan];
                r_best_rem   <= r_remain[r_scan];
            end
        end

        if ((r_state == S_LOAD) && load_hit) begin
            r_arrival[r_idx[ENTRY_W-1:0]] <= r_arr_in;
            r_burst[r_idx[ENTRY_W-1:0]]   <= r_burst_in;
            r_prio[r_idx[ENTRY_W-1:0]]    <= r_pri_in;
            r_remain[r_idx[ENTRY_W-1:0]]  <= r_burst_in;
        end else if ((r_state == S_RUN) && r_found) begin
            r_remain[r_best_idx] <= rem_dec;
        end

        unique case (r_state)
            S_LOAD: begin
                r_res_outcome <= OUT_LOAD;
                r_res_index   <= '0;
                r_res_fin     <= 1'b0;
                r_res_ta      <= '0;
                r_res_wt      <= '0;
            end
            S_RUN: begin
                if (r_found) begin
                    r_res_outcome <= OUT_RUN;
                    r_res_index   <= IDX_W'(r_best_idx);
                    r_res_fin     <= (rem_dec == '0);
                    r_res_ta      <= (rem_dec == '0) ? ta_sat : '0;
                end else begin
                    r_res_outcome <= OUT_IDLE;
                    r_res_index   <= '0;
                    r_res_fin     <= 1'b0;
                    r_res_ta      <= '0;
                end
            end
            S_FIN: begin
                r_res_wt <= (r_res_fin && (r_res_ta >= burst_ext))
                            ? (r_res_ta - burst_ext) : '0;
            end
            default: begin
            end
        endcase

        if (emit_go) begin
            r_out_outcome <= r_res_outcome;
            r_out_index   <= r_res_index;
            r_out_fin     <= r_res_fin;
            r_out_ta      <= r_res_ta;
            r_out_wt      <= r_res_wt;
            r_out_tick    <= r_time;
        end
    end

    assign o_in_ready        = in_ready;
    assign o_out_valid       = r_out_valid;
    assign o_outcome         = r_out_outcome;
    assign o_running_index   = r_out_index;
    assign o_finished        = r_out_fin;
    assign o_turnaround_time = r_out_ta;
    assign o_waiting_time    = r_out_wt;
    assign o_tick_time       = r_out_tick;

endmodule

@@ rtl/pps_checker.sv @@
module pps_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_ready,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic [pps_pkg::OUTCOME_W-1:0]   o_outcome,
    input  logic [pps_pkg::IDX_W-1:0]       o_running_index,
    input  logic                            o_finished,
    input  logic [pps_pkg::TIME_W-1:0]      o_turnaround_time,
    input  logic [pps_pkg::TIME_W-1:0]      o_waiting_time,
    input  logic [pps_pkg::TIME_W-1:0]      o_tick_time
);
    import pps_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_outcome)
            && $stable(o_tick_time) && $stable(o_turnaround_time))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while busy");

    a_no_run_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_outcome != OUT_RUN) |-> !o_finished && (o_running_index == '0))
        else $error("run fields set on load or idle result");

    a_finish_times: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_finished |-> (o_turnaround_time >= o_waiting_time)
            && (o_turnaround_time != '0))
        else $error("inconsistent completion times");

endmodule

bind preemptive_priority_scheduler_unit pps_checker u_pps_checker (.*);

@@ tb/tb_preemptive_priority_scheduler_unit.sv @@
`timescale 1ns / 1ps

module tb_preemptive_priority_scheduler_unit;
    import pps_pkg::*;

    typedef struct packed {
        t_outcome          outcome;
        logic [IDX_W-1:0]  run_index;
        logic              done;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] tick_at;
    } t_sched_result;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 req_valid    = 1'b0;
    logic                 req_command  = CMD_LOAD;
    logic [IDX_W-1:0]     req_index    = '0;
    logic [TIME_W-1:0]    req_arrival  = '0;
    logic [BURST_W-1:0]   req_burst    = '0;
    logic [PRI_W-1:0]     req_priority = '0;
    logic                 res_ready    = 1'b0;

    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [OUTCOME_W-1:0] o_outcome;
    logic [IDX_W-1:0]     o_running_index;
    logic                 o_finished;
    logic [TIME_W-1:0]    o_turnaround_time;
    logic [TIME_W-1:0]    o_waiting_time;
    logic [TIME_W-1:0]    o_tick_time;

    logic                 tbl_valid   [MAX_PROCESSES] = '{default: 1'b0};
    logic [TIME_W-1:0]    tbl_arrival [MAX_PROCESSES] = '{default: '0};
    logic [BURST_W-1:0]   tbl_burst   [MAX_PROCESSES] = '{default: '0};
    logic [PRI_W-1:0]     tbl_pri     [MAX_PROCESSES] = '{default: '0};
    logic [BURST_W-1:0]   tbl_left    [MAX_PROCESSES] = '{default: '0};
    logic [TIME_W-1:0]    sched_time  = '0;

    t_sched_result        pending_results[$];
    logic                 failed    = 1'b0;
    logic                 no_gaps   = 1'b0;

    preemptive_priority_scheduler_unit dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (req_valid),
        .o_in_ready        (o_in_ready),
        .i_command         (req_command),
        .i_process_index   (req_index),
        .i_arrival_time    (req_arrival),
        .i_burst_time      (req_burst),
        .i_priority_level  (req_priority),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (res_ready),
        .o_outcome         (o_outcome),
        .o_running_index   (o_running_index),
        .o_finished        (o_finished),
        .o_turnaround_time (o_turnaround_time),
        .o_waiting_time    (o_waiting_time),
        .o_tick_time       (o_tick_time)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #100_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic t_sched_result schedule_step(input logic cmd,
                                                    input logic [IDX_W-1:0] idx,
                                                    input logic [TIME_W-1:0] arr,
                                                    input logic [BURST_W-1:0] burst,
                                                    input logic [PRI_W-1:0] pri);
        t_sched_result r;
        int            best;
        logic [16:0]   ta;
        r         = '0;
        r.outcome = OUT_LOAD;
        r.tick_at = sched_time;
        if (cmd == CMD_LOAD) begin
            tbl_valid[idx]   = 1'b1;
            tbl_arrival[idx] = arr;
            tbl_burst[idx]   = burst;
            tbl_pri[idx]     = pri;
            tbl_left[idx]    = burst;
            return r;
        end
        best = -1;
        for (int i = 0; i < MAX_PROCESSES; i++) begin
            if (tbl_valid[i] && tbl_left[i] != 0 && tbl_arrival[i] <= sched_time) begin
                if (best < 0 || tbl_pri[i] < tbl_pri[best] ||
                    (tbl_pri[i] == tbl_pri[best] && tbl_arrival[i] < tbl_arrival[best]))
                    best = i;
            end
        end
        if (best < 0) begin
            r.outcome = OUT_IDLE;
        end else begin
            r.outcome      = OUT_RUN;
            r.run_index    = IDX_W'(best);
            tbl_left[best] = tbl_left[best] - 8'd1;
            if (tbl_left[best] == 0) begin
                ta = {1'b0, sched_time} + 17'd1 - {1'b0, tbl_arrival[best]};
                if (ta > 17'hFFFF)
                    ta = 17'hFFFF;
                r.done       = 1'b1;
                r.turnaround = ta[15:0];
                r.waiting    = (ta[15:0] >= 16'(tbl_burst[best])) ?
                               ta[15:0] - 16'(tbl_burst[best]) : '0;
            end
        end
        if (sched_time != 16'hFFFF)
            sched_time = sched_time + 16'd1;
        return r;
    endfunction

    task automatic send_request(input logic cmd, input logic [IDX_W-1:0] idx,
                                input logic [TIME_W-1:0] arr,
                                input logic [BURST_W-1:0] burst,
                                input logic [PRI_W-1:0] pri);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_command  <= cmd;
        req_index    <= idx;
        req_arrival  <= arr;
        req_burst    <= burst;
        req_priority <= pri;
        req_valid    <= 1'b1;
        pending_results.insert(pending_results.size(),
                               schedule_step(cmd, idx, arr, burst, pri));
        do @(posedge clk); while (o_in_ready !== 1'b1);
    endtask

    task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] arr,
                              input logic [BURST_W-1:0] burst, input logic [PRI_W-1:0] pri);
        send_request(CMD_LOAD, idx, arr, burst, pri);
    endtask

    // scramble the fields that a tick ignores
    task automatic tick_once();
        send_request(CMD_TICK, IDX_W'($urandom), TIME_W'($urandom),
                     BURST_W'($urandom), PRI_W'($urandom));
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            failed = 1'b1;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endtask

    initial begin : result_checker
        t_sched_result want;
        int            stall;
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!(rst_n === 1'b1 && o_out_valid === 1'b1));
            if (pending_results.size() == 0) begin
                failed = 1'b1;
                $display("%0t ns: result with no request pending, outcome %0d",
                         $time, o_outcome);
            end else begin
                want = pending_results.pop_front();
                check_field("outcome", 16'(want.outcome), 16'(o_outcome));
                check_field("running_index", 16'(want.run_index), 16'(o_running_index));
                check_field("finished", 16'(want.done), 16'(o_finished));
                check_field("turnaround_time", want.turnaround, o_turnaround_time);
                check_field("waiting_time", want.waiting, o_waiting_time);
                check_field("tick_time", want.tick_at, o_tick_time);
            end
        end
    end

    task automatic test_empty_table_idle();
        tick_once();
        load_entry(4'd3, 16'd0, 8'd0, 3'd1);
        tick_once();
    endtask

    task automatic test_priority_order();
        load_entry(4'd5, 16'd0, 8'd2, 3'd7);
        load_entry(4'd6, 16'd2, 8'd1, 3'd0);
        load_entry(4'd15, 16'hFFFF, 8'hFF, 3'd1);
        repeat (3) tick_once();
        load_entry(4'd8, 16'd5, 8'd1, 3'd3);
        load_entry(4'd9, 16'd4, 8'd1, 3'd3);
        load_entry(4'd10, 16'd4, 8'd1, 3'd3);
        repeat (3) tick_once();
    endtask

    task automatic test_reload_mid_run();
        load_entry(4'd12, 16'd7, 8'd3, 3'd2);
        tick_once();
        load_entry(4'd12, 16'd8, 8'd1, 3'd4);
        repeat (2) tick_once();
    endtask

    task automatic test_random_schedule();
        logic [TIME_W-1:0]  arr;
        logic [BURST_W-1:0] burst;
        logic [PRI_W-1:0]   pri;
        int                 sel;
        for (int n = 0; n < 1800; n++) begin
            if (n % 150 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            if (n % 450 == 449)
                drain_results();
            if ($urandom_range(0, 99) < 65) begin
                tick_once();
            end else begin
                sel   = $urandom_range(0, 9);
                arr   = (sel == 0) ? TIME_W'($urandom) :
                        sched_time + TIME_W'($urandom_range(0, 12));
                burst = (sel == 1) ? BURST_W'($urandom) :
                        (sel == 2) ? 8'd0 : BURST_W'($urandom_range(1, 8));
                pri   = (sel == 3) ? PRI_W'($urandom) : PRI_W'($urandom_range(1, 6));
                load_entry(IDX_W'($urandom), arr, burst, pri);
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_late_arrival();
        no_gaps = 1'b1;
        for (int i = 0; i < MAX_PROCESSES; i++)
            load_entry(IDX_W'(i), TIME_W'($urandom), 8'd0, PRI_W'($urandom));
        // one entry with a long wait since arrival, one that arrives at the limit
        load_entry(4'd0, 16'd0, 8'd5, 3'd0);
        load_entry(4'd1, 16'hFFFF, 8'd4, 3'd0);
        repeat (11) tick_once();
        no_gaps = 1'b0;
    endtask

    initial begin : test_sequence
        int wait_cycles;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table_idle();
        test_priority_order();
        test_reload_mid_run();
        test_random_schedule();
        drain_results();
        test_late_arrival();
        req_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 5000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (40) @(posedge clk);
        if (pending_results.size() != 0)
            $display("%0t ns: %0d results never arrived", $time, pending_results.size());
        if (!failed && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ preemptive_priority_scheduler_unit.f @@
rtl/pps_pkg.sv
rtl/preemptive_priority_scheduler_unit.sv
rtl/pps_checker.sv
tb/tb_preemptive_priority_scheduler_unit.sv
